/* rtl/core/column_geometric_mean_unit_defines.svh */
// Assertion macros for the column geometric mean unit.
`ifndef COLUMN_GEOMETRIC_MEAN_UNIT_DEFINES_SVH
`define COLUMN_GEOMETRIC_MEAN_UNIT_DEFINES_SVH
`define CGM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define CGM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`endif

/* rtl/core/cgm_pkg.sv */
// Shared types, constants and root table for the column geometric mean unit.
package cgm_pkg;
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 40;
   localparam int CNT_W    = 16;
   localparam int GEO_W    = 32;
   localparam int STEP_W   = 6;
   localparam int KIDX_W   = 5;
   localparam int TBL_N    = 24;

   typedef logic [TBL_N:1][31:0] root_tbl_type;

   typedef struct packed {
      logic              load;
      logic              log_step;
      logic              acc;
      logic              div_init;
      logic              div_step;
      logic              exp_init;
      logic              exp_step;
      logic              finish;
      logic [KIDX_W-1:0] exp_idx;
   } cmd_type;

   typedef struct packed {
      logic zero_seen;
      logic last;
      logic out_free;
   } status_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bitv;
      n    = n_in;
      res  = 64'd0;
      bitv = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic root_tbl_type root_tbl_calc();
      root_tbl_type t;
      logic [63:0]  c;
      c = 64'd1 << 31;
      for (int k = 1; k <= TBL_N; k++) begin
         c    = isqrt64(c << 30);
         t[k] = c[31:0];
      end
      return t;
   endfunction

   localparam root_tbl_type ROOT_TBL = root_tbl_calc();
endpackage

/* rtl/core/cgm_ctrl.sv */
// Sequencing state machine for the column geometric mean unit.
module cgm_ctrl #(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               sample_zero,
   output logic               req_tready,
   input  cgm_pkg::status_type stat,
   output cgm_pkg::cmd_type    cmd
);
   import cgm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_LOG, S_ACC, S_PREP, S_DIV, S_EXPI, S_EXP, S_FIN
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;

   localparam logic [STEP_W-1:0] LOG_END = STEP_W'(FRACTION_BITS - 1);
   localparam logic [STEP_W-1:0] DIV_END = STEP_W'(SUM_W - 1);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      cmd.exp_idx = KIDX_W'(cnt_ff + STEP_W'(1));
      req_tready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = sample_zero ? S_ACC : S_LOG;
            end
         end
         S_LOG: begin
            cmd.log_step = 1'b1;
            cnt_in       = cnt_ff + STEP_W'(1);
            if (cnt_ff == LOG_END) state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = stat.last ? S_PREP : S_IDLE;
         end
         S_PREP: begin
            cnt_in = '0;
            if (stat.zero_seen) begin
               state_in = S_FIN;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + STEP_W'(1);
            if (cnt_ff == DIV_END) state_in = S_EXPI;
         end
         S_EXPI: begin
            cmd.exp_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_EXP;
         end
         S_EXP: begin
            cmd.exp_step = 1'b1;
            cnt_in       = cnt_ff + STEP_W'(1);
            if (cnt_ff == LOG_END) state_in = S_FIN;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule

/* rtl/core/cgm_datapath.sv */
// Log, accumulate, divide and exp datapath with output register.
module cgm_datapath #(
   parameter int FRACTION_BITS = 16,
   parameter int MAX_ROWS      = 65535
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cgm_pkg::cmd_type               cmd,
   output cgm_pkg::status_type            stat,
   input  logic [cgm_pkg::SAMPLE_W-1:0]   sample,
   input  logic                          last_in,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cgm_pkg::GEO_W-1:0]      geo_mean,
   output logic                          had_zero
);
   import cgm_pkg::*;

   localparam int F     = FRACTION_BITS;
   localparam int LOG_W = 4 + F;
   localparam int INT_W = SUM_W - F;

   logic [30:0]       y_ff, y_in;
   logic [LOG_W-1:0]  r_ff, r_in;
   logic              last_ff, zero_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              seen_ff, seen_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W:0]    rem_ff, rem_in;
   logic [F-1:0]      frac_ff, frac_in;
   logic              valid_ff, valid_in;
   logic [GEO_W-1:0]  geo_ff, geo_in;
   logic              hz_ff, hz_in;

   logic [3:0]        e;
   logic [61:0]       sq;
   logic [31:0]       sq_sh;
   logic [62:0]       prod;
   logic [SUM_W:0]    sum_t;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic [INT_W-1:0]  ip;
   logic [45:0]       scaled;

   always_comb begin
      e = '0;
      for (int j = 1; j < SAMPLE_W; j++) begin
         if (sample[j]) e = 4'(j);
      end
   end

   assign sq     = 62'(y_ff) * 62'(y_ff);
   assign sq_sh  = sq[61:30];
   assign prod   = 63'(y_ff) * 63'(ROOT_TBL[cmd.exp_idx]);
   assign sum_t  = {1'b0, sum_ff} + (SUM_W+1)'(r_ff);
   assign trial  = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
   assign diff   = trial - {1'b0, cnt_ff};
   assign ip     = quo_ff[SUM_W-1:F];
   assign scaled = (46'(y_ff) << ip[3:0]) >> 14;

   always_comb begin
      y_in     = y_ff;
      r_in     = r_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      seen_in  = seen_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      frac_in  = frac_ff;
      valid_in = valid_ff && !rsp_tready;
      geo_in   = geo_ff;
      hz_in    = hz_ff;
      if (cmd.load) begin
         y_in = 31'({15'd0, sample} << (30 - 32'(e)));
         r_in = LOG_W'(e);
      end
      if (cmd.log_step) begin
         if (sq_sh[31]) begin
            y_in = sq_sh[31:1];
            r_in = {r_ff[LOG_W-2:0], 1'b1};
         end else begin
            y_in = sq_sh[30:0];
            r_in = {r_ff[LOG_W-2:0], 1'b0};
         end
      end
      if (cmd.acc) begin
         if (zero_ff) seen_in = 1'b1;
         else sum_in = sum_t[SUM_W] ? {SUM_W{1'b1}} : sum_t[SUM_W-1:0];
         if (cnt_ff < CNT_W'(MAX_ROWS)) cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.div_init) begin
         quo_in = sum_ff;
         rem_in = '0;
      end
      if (cmd.div_step) begin
         if (!diff[CNT_W]) begin
            rem_in = diff;
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
      if (cmd.exp_init) begin
         y_in    = 31'(1) << 30;
         frac_in = quo_ff[F-1:0];
      end
      if (cmd.exp_step) begin
         frac_in = frac_ff << 1;
         if (frac_ff[F-1]) y_in = prod[60:30];
      end
      if (cmd.finish) begin
         valid_in = 1'b1;
         hz_in    = seen_ff;
         if (seen_ff) geo_in = '0;
         else if (ip > INT_W'(15)) geo_in = {GEO_W{1'b1}};
         else geo_in = scaled[GEO_W-1:0];
         sum_in  = '0;
         cnt_in  = '0;
         seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         cnt_ff   <= '0;
         seen_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         seen_ff  <= seen_in;
         valid_ff <= valid_in;
      end
      y_ff    <= y_in;
      r_ff    <= r_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      frac_ff <= frac_in;
      geo_ff  <= geo_in;
      hz_ff   <= hz_in;
      if (cmd.load) begin
         last_ff <= last_in;
         zero_ff <= (sample == '0);
      end
   end

   assign stat.zero_seen = seen_ff;
   assign stat.last      = last_ff;
   assign stat.out_free  = !valid_ff || rsp_tready;
   assign rsp_tvalid     = valid_ff;
   assign geo_mean       = geo_ff;
   assign had_zero       = hz_ff;
endmodule

/* rtl/core/column_geometric_mean_unit.sv */
// Top level of the column geometric mean unit.
// Usage: stream the samples of one column on the req_ channel, one word per
// handshake, with req_tlast on the final sample. Each column produces one
// result word on the rsp_ channel: the geometric mean in unsigned Q16.16 on
// rsp_tdata and a zero-sample flag on rsp_tuser (mean then reads 0).
// A sample is loaded, then, unless it is zero, takes one squaring step per
// fraction bit of log2, then an accumulate step. The last sample of a
// column adds the mean computation: a prepare step, a bit-serial divide
// with one step per bit of the 40-bit sum, an exp2 setup step, FRACTION_BITS
// steps of the exp2 multiplier and a load of the output register. The log2
// squaring loop sets the per-sample rate; the divider sets the column
// latency. A column with a zero sample skips divide and exp2. The result
// sits in an output register; while the receiver stalls the unit keeps
// taking samples of the next column and only waits when that column's
// result is ready. Reset clears the running sum, count, zero-seen flag
// and output valid flag.
module column_geometric_mean_unit #(
   parameter int MAX_ROWS      = 65535,
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] sample
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] geo_mean
   output logic        rsp_tuser   // [0] had_zero
);
   import cgm_pkg::*;
   `include "column_geometric_mean_unit_defines.svh"

   cmd_type    cmd;
   status_type stat;

   cgm_ctrl #(.FRACTION_BITS(FRACTION_BITS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .sample_zero (req_tdata == '0),
      .req_tready  (req_tready),
      .stat        (stat),
      .cmd         (cmd)
   );

   cgm_datapath #(.FRACTION_BITS(FRACTION_BITS), .MAX_ROWS(MAX_ROWS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .sample     (req_tdata),
      .last_in    (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .geo_mean   (rsp_tdata),
      .had_zero   (rsp_tuser)
   );

   `CGM_ASSERT_SAME(a_zero_result, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `CGM_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   `CGM_ASSERT_SAME(a_finish_free, clock, reset, cmd.finish, !rsp_tvalid || rsp_tready)
endmodule

/* test/column_geometric_mean_unit_test.sv */
// Self-checking testbench for the column geometric mean unit.
module column_geometric_mean_unit_test;
   import cgm_pkg::*;

   localparam int FRAC       = 16;
   localparam int MAX_ROWS   = 65535;
   localparam int CYCLE_CAP  = 600000;
   localparam int LONG_HOLD  = 600;
   localparam logic [39:0] SUM_MAX = 40'hFF_FFFF_FFFF;

   typedef struct {
      logic [GEO_W-1:0] geo_mean;
      logic             had_zero;
   } mean_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   mean_word_type pending_means[$];
   logic [SUM_W-1:0] acc_log_sum;
   logic [CNT_W-1:0] acc_count;
   logic             acc_zero;
   bit               gaps_on;
   bit               hold_long;
   int               fail_count;
   int               cycle_count;

   column_geometric_mean_unit #(
      .MAX_ROWS     (MAX_ROWS),
      .FRACTION_BITS(FRAC)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] b;
      n = n_in;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] log2_q16(input logic [15:0] x);
      int          e;
      logic [63:0] y;
      logic [63:0] r;
      e = 0;
      while (e < 15 && (x >> (e + 1)) != 0) e++;
      y = 64'(x) << (30 - e);
      r = 64'(e);
      for (int k = 0; k < FRAC; k++) begin
         y = (y * y) >> 30;
         r = r << 1;
         if (y >= (64'd1 << 31)) begin
            r = r | 64'd1;
            y = y >> 1;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] exp2_frac(input logic [63:0] f);
      logic [63:0] y;
      logic [63:0] c;
      y = 64'd1 << 30;
      c = 64'd1 << 31;
      for (int k = 1; k <= FRAC; k++) begin
         c = int_sqrt(c << 30);
         if (f[FRAC-k]) y = (y * c) >> 30;
      end
      return y;
   endfunction

   task automatic accumulate_sample(input logic [15:0] s, input logic l);
      logic [63:0]   t;
      logic [63:0]   q;
      logic [63:0]   ip;
      logic [63:0]   g;
      mean_word_type w;
      if (s == 0) begin
         acc_zero = 1'b1;
      end else begin
         t = 64'(acc_log_sum) + log2_q16(s);
         acc_log_sum = (t > 64'(SUM_MAX)) ? SUM_MAX : t[SUM_W-1:0];
      end
      if (acc_count < MAX_ROWS) acc_count = acc_count + 1'b1;
      if (l) begin
         if (acc_zero) begin
            g = 64'd0;
         end else begin
            q  = 64'(acc_log_sum) / 64'(acc_count);
            ip = q >> FRAC;
            if (ip > 15) begin
               g = 64'hFFFF_FFFF;
            end else begin
               g = exp2_frac(q & ((64'd1 << FRAC) - 1));
               if (ip <= 14) g = g >> (14 - ip);
               else          g = g << (ip - 14);
            end
         end
         w.geo_mean = g[31:0];
         w.had_zero = acc_zero;
         pending_means.push_back(w);
         acc_log_sum = '0;
         acc_count   = '0;
         acc_zero    = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
               cycle_count);
      fail_count++;
   endtask

   task automatic send_sample(input logic [15:0] s, input logic l);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accumulate_sample(s, l);
   endtask

   task automatic send_column(input int len, input int zero_pct);
      logic [15:0] s;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0:       s = 16'hFFFF;
            1:       s = 16'($urandom_range(1, 15));
            default: s = 16'($urandom);
         endcase
         if ($urandom_range(0, 99) < zero_pct) s = 16'd0;
         send_sample(s, i == len - 1);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic test_single_samples();
      send_sample(16'd1, 1'b1);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'd0, 1'b1);
      send_sample(16'd2, 1'b1);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h7FFF, 1'b1);
      send_sample(16'h5555, 1'b1);
      send_sample(16'hAAAA, 1'b1);
   endtask

   task automatic test_multi_sample_columns();
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'd1, 1'b0);
      send_sample(16'd1, 1'b1);
      send_sample(16'd3, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'd9, 1'b1);
      send_sample(16'd1, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'd0, 1'b0);
      send_sample(16'd0, 1'b1);
      send_sample(16'd100, 1'b0);
      send_sample(16'd200, 1'b0);
      send_sample(16'd0, 1'b1);
   endtask

   task automatic test_random_columns(input int items);
      int sent;
      int len;
      sent = 0;
      while (sent < items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         send_column(len, ($urandom_range(0, 4) == 0) ? 15 : 0);
         sent += len;
      end
   endtask

   task automatic test_backpressure();
      hold_long = 1'b1;
      test_random_columns(60);
      wait_drained();
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("column_geometric_mean_unit verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_means.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 32'd0);
         end else begin
            if (rsp_tdata !== pending_means[0].geo_mean)
               report_mismatch("geo_mean", rsp_tdata, pending_means[0].geo_mean);
            if (rsp_tuser !== pending_means[0].had_zero)
               report_mismatch("had_zero", 32'(rsp_tuser), 32'(pending_means[0].had_zero));
            void'(pending_means.pop_front());
         end
      end
   end

   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      acc_log_sum = '0;
      acc_count   = '0;
      acc_zero    = 1'b0;
      gaps_on     = 1'b1;
      hold_long   = 1'b0;
      fail_count  = 0;
      cycle_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_samples();
      test_multi_sample_columns();
      wait_drained();
      test_random_columns(600);
      test_backpressure();
      test_random_columns(150);
      gaps_on = 1'b0;
      test_random_columns(100);
      wait_drained();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("column_geometric_mean_unit verification clean");
      end else begin
         $display("column_geometric_mean_unit verification failed");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cgm_pkg.sv
rtl/core/cgm_ctrl.sv
rtl/core/cgm_datapath.sv
rtl/core/column_geometric_mean_unit.sv
test/column_geometric_mean_unit_test.sv
